FILE: rtl/core/esn_pkg.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Number extraction package
// Widths, character constants and shared types for the number extraction
// and sort block.
// ----------------------------------------------------------------------------
package esn_pkg;

    // Field widths fixed by the item format.
    localparam int CHAR_W  = 8;
    localparam int VALUE_W = 31;

    // Character codes that bound the decimal digits.
    localparam logic [CHAR_W-1:0] CHAR_ZERO = 8'h30;
    localparam logic [CHAR_W-1:0] CHAR_NINE = 8'h39;

    // Saturation limit of an extracted number.
    localparam logic [VALUE_W-1:0] VALUE_MAX = 31'h7FFF_FFFF;

    // A finished digit run handed from the parser to the number store.
    typedef struct packed {
        logic               valid;
        logic [VALUE_W-1:0] value;
    } t_commit;

endpackage

FILE: rtl/core/esn_if.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Number extraction channel interfaces
// Valid/ready channels for text characters in and sorted numbers out.
// ----------------------------------------------------------------------------

// Input channel: one text character or the end-of-text marker.
interface esn_in_if;
    logic                       valid;
    logic                       ready;
    logic [esn_pkg::CHAR_W-1:0] char_code;
    logic                       end_of_text;

    modport source (output valid, output char_code, output end_of_text, input ready);
    modport sink   (input valid, input char_code, input end_of_text, output ready);
endinterface

// Output channel: one sorted number with its run flags.
interface esn_out_if;
    logic                        valid;
    logic                        ready;
    logic [esn_pkg::VALUE_W-1:0] value;
    logic                        last;
    logic                        empty_res;
    logic                        overflowed;

    modport source (output valid, output value, output last, output empty_res,
                    output overflowed, input ready);
    modport sink   (input valid, input value, input last, input empty_res,
                    input overflowed, output ready);
endinterface

FILE: rtl/core/esn_parse.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Digit run parser
// Accumulates decimal digit runs with saturation and reports each finished
// run to the number store.
// ----------------------------------------------------------------------------
module esn_parse (
    input  logic                        i_clk,
    input  logic                        i_rst_n,
    input  logic                        i_accept,
    input  logic [esn_pkg::CHAR_W-1:0]  i_char_code,
    input  logic                        i_end_of_text,
    output esn_pkg::t_commit            o_commit
);

    localparam int WIDE_W = esn_pkg::VALUE_W + 4;

    logic [esn_pkg::VALUE_W-1:0] r_acc;
    logic [esn_pkg::VALUE_W-1:0] n_acc;
    logic                        r_in_run;
    logic                        n_in_run;
    logic                        w_is_digit;
    logic [esn_pkg::CHAR_W-1:0]  w_digit;
    logic [WIDE_W-1:0]           w_acc_wide;
    logic [WIDE_W-1:0]           w_next_wide;

    // Digit decode and acc * 10 + digit, formed as two shifts and an add.
    assign w_is_digit  = (i_char_code >= esn_pkg::CHAR_ZERO) &&
                         (i_char_code <= esn_pkg::CHAR_NINE);
    assign w_digit     = i_char_code - esn_pkg::CHAR_ZERO;
    assign w_acc_wide  = WIDE_W'(r_acc);
    assign w_next_wide = (w_acc_wide << 3) + (w_acc_wide << 1) + WIDE_W'(w_digit);

    // A run closes on any non-digit character and on end of text.
    assign o_commit.valid = i_accept && r_in_run && (i_end_of_text || !w_is_digit);
    assign o_commit.value = r_acc;

    // Next accumulator state.
    always_comb begin
        n_acc    = r_acc;
        n_in_run = r_in_run;
        if (i_accept) begin
            if (!i_end_of_text && w_is_digit) begin
                if (w_next_wide > WIDE_W'(esn_pkg::VALUE_MAX)) begin
                    n_acc = esn_pkg::VALUE_MAX;
                end else begin
                    n_acc = w_next_wide[esn_pkg::VALUE_W-1:0];
                end
                n_in_run = 1'b1;
            end else begin
                n_acc    = '0;
                n_in_run = 1'b0;
            end
        end
    end

    // Accumulator registers.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_acc    <= '0;
            r_in_run <= 1'b0;
        end else begin
            r_acc    <= n_acc;
            r_in_run <= n_in_run;
        end
    end

endmodule

FILE: rtl/core/esn_sort_store.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Number store and sort engine
// Holds the numbers in a synchronous memory, runs an exchange sort over it
// one entry per cycle and drives each sorted number to the output channel.
// ----------------------------------------------------------------------------
module esn_sort_store #(
    parameter int MAX_NUMBERS = 64
) (
    input  logic                 i_clk,
    input  logic                 i_rst_n,
    input  logic                 i_accept,
    input  logic                 i_end_of_text,
    input  esn_pkg::t_commit     i_commit,
    output logic                 o_in_ready,
    esn_out_if.source            o_out
);

    localparam int ADDR_W = (MAX_NUMBERS > 1) ? $clog2(MAX_NUMBERS) : 1;
    localparam int CNT_W  = $clog2(MAX_NUMBERS + 1);

    typedef enum logic [2:0] {
        S_IDLE,
        S_READ_I,
        S_CAPT_I,
        S_SCAN,
        S_EMIT
    } t_state;

    t_state                      r_state;
    t_state                      n_state;
    logic [ADDR_W-1:0]           r_i;
    logic [ADDR_W-1:0]           n_i;
    logic [ADDR_W-1:0]           r_j;
    logic [ADDR_W-1:0]           n_j;
    logic [esn_pkg::VALUE_W-1:0] r_cur;
    logic [esn_pkg::VALUE_W-1:0] n_cur;
    logic [CNT_W-1:0]            r_count;
    logic [CNT_W-1:0]            n_count;
    logic                        r_ovf;
    logic                        n_ovf;
    logic                        r_out_valid;
    logic                        n_out_valid;
    logic [esn_pkg::VALUE_W-1:0] r_out_value;
    logic [esn_pkg::VALUE_W-1:0] n_out_value;
    logic                        r_out_last;
    logic                        n_out_last;
    logic                        r_out_empty;
    logic                        n_out_empty;
    logic                        r_out_ovf;
    logic                        n_out_ovf;

    logic [esn_pkg::VALUE_W-1:0] r_mem [MAX_NUMBERS];
    logic [esn_pkg::VALUE_W-1:0] r_rdata;
    logic                        w_we;
    logic [ADDR_W-1:0]           w_waddr;
    logic [esn_pkg::VALUE_W-1:0] w_wdata;
    logic [ADDR_W-1:0]           w_raddr;

    logic [CNT_W-1:0]            w_cnt_m1;
    logic                        w_i_is_last;
    logic                        w_swap;
    logic [esn_pkg::VALUE_W-1:0] w_min;

    assign w_cnt_m1    = r_count - CNT_W'(1);
    assign w_i_is_last = (CNT_W'(r_i) == w_cnt_m1);
    assign w_swap      = (r_cur > r_rdata);
    assign w_min       = w_swap ? r_rdata : r_cur;

    // Sort sequencer: selection of the minimum of entries i..count-1 per pass.
    always_comb begin
        n_state     = r_state;
        n_i         = r_i;
        n_j         = r_j;
        n_cur       = r_cur;
        n_count     = r_count;
        n_ovf       = r_ovf;
        n_out_valid = r_out_valid;
        n_out_value = r_out_value;
        n_out_last  = r_out_last;
        n_out_empty = r_out_empty;
        n_out_ovf   = r_out_ovf;
        w_we        = 1'b0;
        w_waddr     = r_count[ADDR_W-1:0];
        w_wdata     = i_commit.value;
        w_raddr     = r_i;
        o_in_ready  = 1'b0;

        case (r_state)
            S_IDLE: begin
                o_in_ready = 1'b1;
                // Store a finished run, or note that it was dropped.
                if (i_commit.valid) begin
                    if (r_count < CNT_W'(MAX_NUMBERS)) begin
                        w_we    = 1'b1;
                        n_count = r_count + CNT_W'(1);
                    end else begin
                        n_ovf = 1'b1;
                    end
                end
                if (i_accept && i_end_of_text) begin
                    if (n_count == '0) begin
                        n_out_valid = 1'b1;
                        n_out_value = '0;
                        n_out_last  = 1'b1;
                        n_out_empty = 1'b1;
                        n_out_ovf   = n_ovf;
                        n_state     = S_EMIT;
                    end else begin
                        n_i     = '0;
                        n_state = S_READ_I;
                    end
                end
            end
            S_READ_I: begin
                w_raddr = r_i;
                n_state = S_CAPT_I;
            end
            S_CAPT_I: begin
                n_cur = r_rdata;
                if (w_i_is_last) begin
                    n_out_valid = 1'b1;
                    n_out_value = r_rdata;
                    n_out_last  = 1'b1;
                    n_out_empty = 1'b0;
                    n_out_ovf   = r_ovf;
                    n_state     = S_EMIT;
                end else begin
                    n_j     = w_cnt_m1[ADDR_W-1:0];
                    w_raddr = w_cnt_m1[ADDR_W-1:0];
                    n_state = S_SCAN;
                end
            end
            S_SCAN: begin
                // Swap the held value with a smaller entry further down.
                if (w_swap) begin
                    w_we    = 1'b1;
                    w_waddr = r_j;
                    w_wdata = r_cur;
                end
                n_cur = w_min;
                if (r_j == ADDR_W'(r_i + ADDR_W'(1))) begin
                    n_out_valid = 1'b1;
                    n_out_value = w_min;
                    n_out_last  = w_i_is_last;
                    n_out_empty = 1'b0;
                    n_out_ovf   = r_ovf;
                    n_state     = S_EMIT;
                end else begin
                    n_j     = r_j - ADDR_W'(1);
                    w_raddr = r_j - ADDR_W'(1);
                end
            end
            S_EMIT: begin
                if (o_out.ready) begin
                    n_out_valid = 1'b0;
                    if (r_out_last) begin
                        n_count = '0;
                        n_ovf   = 1'b0;
                        n_state = S_IDLE;
                    end else begin
                        n_i     = r_i + ADDR_W'(1);
                        n_state = S_READ_I;
                    end
                end
            end
            default: begin
                n_state = S_IDLE;
            end
        endcase
    end

    // State and registered outputs.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= S_IDLE;
            r_i         <= '0;
            r_j         <= '0;
            r_count     <= '0;
            r_ovf       <= 1'b0;
            r_out_valid <= 1'b0;
        end else begin
            r_state     <= n_state;
            r_i         <= n_i;
            r_j         <= n_j;
            r_count     <= n_count;
            r_ovf       <= n_ovf;
            r_out_valid <= n_out_valid;
        end
        r_cur       <= n_cur;
        r_out_value <= n_out_value;
        r_out_last  <= n_out_last;
        r_out_empty <= n_out_empty;
        r_out_ovf   <= n_out_ovf;
    end

    // Number memory: one write and one registered read per cycle.
    always_ff @(posedge i_clk) begin
        if (w_we) begin
            r_mem[w_waddr] <= w_wdata;
        end
        r_rdata <= r_mem[w_raddr];
    end

    assign o_out.valid      = r_out_valid;
    assign o_out.value      = r_out_value;
    assign o_out.last       = r_out_last;
    assign o_out.empty_res  = r_out_empty;
    assign o_out.overflowed = r_out_ovf;

endmodule

FILE: rtl/core/extract_and_sort_numbers.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Extract and sort numbers
// Pulls decimal numbers out of a character stream and returns them sorted.
// ----------------------------------------------------------------------------
// Text characters are taken one per cycle; each maximal run of ASCII digits
// becomes one number, saturating at 2147483647, and is written to a memory of
// MAX_NUMBERS entries (later numbers are dropped and flagged as overflowed).
// The transaction that carries end_of_text starts the sort; no further input
// is taken until the last result of the run has been delivered. For each
// result k (from 0) of N stored numbers, entry k is read and then entries
// N-1 down to k+1 are scanned one entry per cycle through the single read port,
// before the result waits for its output transaction with the sink.
// A text without numbers yields a single result flagged empty_res. The memory
// needs no clearing after reset: only entries written in the current text
// are read.
// ----------------------------------------------------------------------------
module extract_and_sort_numbers #(
    parameter int MAX_NUMBERS = 64
) (
    input  logic      i_clk,
    input  logic      i_rst_n,
    esn_in_if.sink    i_in,
    esn_out_if.source o_out
);

    logic             w_in_ready;
    logic             w_accept;
    esn_pkg::t_commit w_commit;

    assign i_in.ready = w_in_ready;
    assign w_accept   = i_in.valid && w_in_ready;

    // Digit run parser.
    esn_parse u_parse (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .i_accept      (w_accept),
        .i_char_code   (i_in.char_code),
        .i_end_of_text (i_in.end_of_text),
        .o_commit      (w_commit)
    );

    // Number memory, sorter and output register.
    esn_sort_store #(
        .MAX_NUMBERS (MAX_NUMBERS)
    ) u_sort_store (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .i_accept      (w_accept),
        .i_end_of_text (i_in.end_of_text),
        .i_commit      (w_commit),
        .o_in_ready    (w_in_ready),
        .o_out         (o_out)
    );

    // Input is never taken while a result is pending.
    a_no_overlap: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        !(i_in.ready && o_out.valid))
        else $error("input ready while a result is pending");

    // End of text stops input intake for the sort.
    a_eot_stalls: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (i_in.valid && i_in.ready && i_in.end_of_text) |=> !i_in.ready)
        else $error("input taken right after end of text");

    // The last result of a run reopens the input.
    a_last_reopens: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_out.valid && o_out.ready && o_out.last) |=> i_in.ready)
        else $error("input not ready after the last result");

    // An empty result is the only and final result, with a zero value.
    a_empty_form: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_out.valid && o_out.empty_res) |-> (o_out.last && o_out.value == '0))
        else $error("malformed empty result");

endmodule

FILE: sim/tb_extract_and_sort_numbers.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Extract and sort numbers testbench
// Sends texts one character per transaction. A model in the bench follows
// the digit runs and the number store, and sorts the numbers when the text
// ends. Each result is compared field by field with the oldest expected
// result. A short table of directed texts comes first, then random texts.
// Both channels idle at random, and the sink holds off once for a long time.
// ----------------------------------------------------------------------------
module tb_extract_and_sort_numbers;

    localparam int MAX_NUMBERS  = 64;
    localparam int RANDOM_ITEMS = 240;
    localparam int HOLD_CYCLES  = 400;
    localparam int DRAIN_CYCLES = 100;
    localparam int CYCLE_LIMIT  = 200000;

    // One result of the block, packed in port order.
    typedef struct packed {
        logic [esn_pkg::VALUE_W-1:0] value;
        logic                        last;
        logic                        empty_res;
        logic                        overflowed;
    } t_number_result;

    // One row of the directed text, with a typed result where it is obvious.
    typedef struct {
        logic [esn_pkg::CHAR_W-1:0] char_code;
        logic                       end_of_text;
        bit                         typed;
        t_number_result             result;
    } t_text_row;

    localparam t_number_result NO_RESULT    = '0;
    localparam t_number_result EMPTY_RESULT = '{value: '0, last: 1'b1,
                                                empty_res: 1'b1, overflowed: 1'b0};
    localparam t_number_result SAT_RESULT   = '{value: esn_pkg::VALUE_MAX, last: 1'b1,
                                                empty_res: 1'b0, overflowed: 1'b0};

    logic clk;
    logic rst_n;

    esn_in_if  in_ch();
    esn_out_if out_ch();

    extract_and_sort_numbers #(
        .MAX_NUMBERS(MAX_NUMBERS)
    ) i_dut (
        .i_clk  (clk),
        .i_rst_n(rst_n),
        .i_in   (in_ch),
        .o_out  (out_ch)
    );

    // Model state: the digit run in progress and the numbers found so far.
    logic [esn_pkg::VALUE_W-1:0] run_value;
    bit                          run_open;
    logic [esn_pkg::VALUE_W-1:0] found_numbers[$];
    bit                          numbers_dropped;
    t_number_result              text_results[$];
    t_number_result              expected_numbers[$];

    // Pacing controls shared by the stimulus and the sink.
    bit             no_idle;
    bit             hold_req;
    bit             hold_served;
    bit             typed_on;
    t_number_result typed_res;

    int fail_count;
    int items_sent;
    int cycles;

    t_text_row directed_rows[25];

    // Clock generation.
    initial begin
        clk = 1'b0;
        forever #4 clk = ~clk;
    end

    // Closes an open digit run and stores its number, or drops it when full.
    function automatic void close_run();
        if (!run_open) return;
        if (found_numbers.size() < MAX_NUMBERS) found_numbers.push_back(run_value);
        else numbers_dropped = 1'b1;
        run_value = '0;
        run_open  = 1'b0;
    endfunction

    // Follows one accepted character; at end of text fills text_results.
    function automatic void extract_step(logic [esn_pkg::CHAR_W-1:0] c, logic eot);
        longint unsigned             wide;
        logic [esn_pkg::VALUE_W-1:0] key;
        int                          j;
        t_number_result              r;
        if (!eot) begin
            if (c >= esn_pkg::CHAR_ZERO && c <= esn_pkg::CHAR_NINE) begin
                wide = 64'(run_value) * 64'd10 + 64'(c - esn_pkg::CHAR_ZERO);
                run_value = (wide > 64'(esn_pkg::VALUE_MAX)) ? esn_pkg::VALUE_MAX
                                                             : wide[esn_pkg::VALUE_W-1:0];
                run_open  = 1'b1;
            end else begin
                close_run();
            end
            return;
        end
        close_run();
        if (found_numbers.size() == 0) begin
            r = EMPTY_RESULT;
            r.overflowed = numbers_dropped;
            text_results.push_back(r);
        end else begin
            // Ascending insertion sort; duplicates are kept.
            for (int i = 1; i < found_numbers.size(); i++) begin
                key = found_numbers[i];
                j = i;
                while (j > 0 && found_numbers[j-1] > key) begin
                    found_numbers[j] = found_numbers[j-1];
                    j--;
                end
                found_numbers[j] = key;
            end
            foreach (found_numbers[k]) begin
                r.value      = found_numbers[k];
                r.last       = (k == found_numbers.size() - 1);
                r.empty_res  = 1'b0;
                r.overflowed = numbers_dropped;
                text_results.push_back(r);
            end
        end
        found_numbers.delete();
        run_value       = '0;
        run_open        = 1'b0;
        numbers_dropped = 1'b0;
    endfunction

    // Counts a failure and reports the first few in detail.
    function automatic void note_failure(string what, t_number_result want,
                                         t_number_result got);
        fail_count++;
        if (fail_count <= 10)
            $display({"%s: expected value %0d last %0b empty %0b ovf %0b, ",
                      "got value %0d last %0b empty %0b ovf %0b"},
                     what, want.value, want.last, want.empty_res, want.overflowed,
                     got.value, got.last, got.empty_res, got.overflowed);
    endfunction

    function automatic logic [esn_pkg::CHAR_W-1:0] any_non_digit();
        logic [esn_pkg::CHAR_W-1:0] b;
        do b = 8'($urandom_range(255));
        while (b >= esn_pkg::CHAR_ZERO && b <= esn_pkg::CHAR_NINE);
        return b;
    endfunction

    function automatic logic [esn_pkg::CHAR_W-1:0] any_digit();
        return esn_pkg::CHAR_ZERO + 8'($urandom_range(9));
    endfunction

    // Offers one character and waits for its transaction.
    task automatic drive_char(input logic [esn_pkg::CHAR_W-1:0] c, input logic eot);
        while (!no_idle && $urandom_range(99) < 17) begin
            in_ch.valid = 1'b0;
            @(negedge clk);
        end
        in_ch.valid       = 1'b1;
        in_ch.char_code   = c;
        in_ch.end_of_text = eot;
        @(posedge clk);
        while (!in_ch.ready) @(posedge clk);
        @(negedge clk);
        items_sent++;
    endtask

    // Random text: mostly digit runs between separators, some raw noise.
    task automatic send_random_text();
        int kind;
        int runs;
        int len;
        kind = $urandom_range(99);
        if (kind < 70) begin
            runs = $urandom_range(6);
            for (int r = 0; r < runs; r++) begin
                repeat ($urandom_range(3, (r == 0) ? 0 : 1)) drive_char(any_non_digit(), 1'b0);
                len = ($urandom_range(9) == 0) ? $urandom_range(12, 9) : $urandom_range(4, 1);
                repeat (len) drive_char(any_digit(), 1'b0);
            end
            if ($urandom_range(1) == 1)
                repeat ($urandom_range(2, 1)) drive_char(any_non_digit(), 1'b0);
        end else if (kind < 90) begin
            repeat ($urandom_range(12, 1)) drive_char(8'($urandom_range(255)), 1'b0);
        end else begin
            repeat ($urandom_range(3)) drive_char(any_non_digit(), 1'b0);
        end
        drive_char(8'($urandom_range(255)), 1'b1);
    endtask

    // Fills the store and drops one more number, closed by the end of text.
    // The sink then holds off while the next text is offered.
    task automatic send_crowded_text();
        repeat (MAX_NUMBERS) begin
            drive_char(any_digit(), 1'b0);
            drive_char(any_non_digit(), 1'b0);
        end
        repeat ($urandom_range(3, 1)) drive_char(any_digit(), 1'b0);
        drive_char(8'($urandom_range(255)), 1'b1);
        hold_req = 1'b1;
    endtask

    // Sink pacing: random stalls, a stall-free stretch and one long hold.
    initial begin : sink_pacing
        int hold_left;
        hold_left    = 0;
        out_ch.ready = 1'b0;
        forever begin
            @(negedge clk);
            if (hold_left > 0) begin
                out_ch.ready = 1'b0;
                hold_left--;
            end else if (hold_req && !hold_served) begin
                hold_served  = 1'b1;
                hold_left    = HOLD_CYCLES - 1;
                out_ch.ready = 1'b0;
            end else begin
                out_ch.ready = no_idle || ($urandom_range(99) >= 17);
            end
        end
    end

    // Predicts on each input transaction and checks each output transaction.
    always @(posedge clk) begin : result_check
        t_number_result got;
        t_number_result want;
        if (rst_n) begin
            if (in_ch.valid && in_ch.ready) begin
                extract_step(in_ch.char_code, in_ch.end_of_text);
                if (typed_on && in_ch.end_of_text) expected_numbers.push_back(typed_res);
                else foreach (text_results[k]) expected_numbers.push_back(text_results[k]);
                text_results.delete();
            end
            if (out_ch.valid && out_ch.ready) begin
                got = '{value: out_ch.value, last: out_ch.last,
                        empty_res: out_ch.empty_res, overflowed: out_ch.overflowed};
                if (expected_numbers.size() == 0) begin
                    note_failure("unexpected result", NO_RESULT, got);
                end else begin
                    want = expected_numbers.pop_front();
                    if (want !== got) note_failure("mismatch", want, got);
                end
            end
        end
    end

    // Cycle limit for a hung run.
    initial begin : watchdog
        cycles = 0;
        while (cycles < CYCLE_LIMIT) begin
            @(posedge clk);
            cycles++;
        end
        $display("status: fail");
        $finish;
    end

    // Main sequence: reset, directed table, random texts, drain.
    initial begin : stimulus
        int text_idx;
        rst_n             = 1'b0;
        in_ch.valid       = 1'b0;
        in_ch.char_code   = '0;
        in_ch.end_of_text = 1'b0;
        run_value         = '0;
        run_open          = 1'b0;
        numbers_dropped   = 1'b0;
        no_idle           = 1'b0;
        hold_req          = 1'b0;
        hold_served       = 1'b0;
        typed_on          = 1'b0;
        typed_res         = NO_RESULT;
        fail_count        = 0;
        items_sent        = 0;

        directed_rows = '{
            // End of text at once; its character is ignored.
            '{8'h39, 1'b1, 1'b1, EMPTY_RESULT},
            // Ten nines saturate the run.
            '{"9", 1'b0, 1'b0, NO_RESULT}, '{"9", 1'b0, 1'b0, NO_RESULT},
            '{"9", 1'b0, 1'b0, NO_RESULT}, '{"9", 1'b0, 1'b0, NO_RESULT},
            '{"9", 1'b0, 1'b0, NO_RESULT}, '{"9", 1'b0, 1'b0, NO_RESULT},
            '{"9", 1'b0, 1'b0, NO_RESULT}, '{"9", 1'b0, 1'b0, NO_RESULT},
            '{"9", 1'b0, 1'b0, NO_RESULT}, '{"9", 1'b0, 1'b0, NO_RESULT},
            '{8'h00, 1'b1, 1'b1, SAT_RESULT},
            // Bytes next to the digit range, NUL and 0xFF split runs;
            // leading zeros, duplicates, a zero and a run closed by end of text.
            '{"7", 1'b0, 1'b0, NO_RESULT}, '{"/", 1'b0, 1'b0, NO_RESULT},
            '{"0", 1'b0, 1'b0, NO_RESULT}, '{"0", 1'b0, 1'b0, NO_RESULT},
            '{"3", 1'b0, 1'b0, NO_RESULT}, '{8'h00, 1'b0, 1'b0, NO_RESULT},
            '{"3", 1'b0, 1'b0, NO_RESULT}, '{":", 1'b0, 1'b0, NO_RESULT},
            '{8'hFF, 1'b0, 1'b0, NO_RESULT}, '{"0", 1'b0, 1'b0, NO_RESULT},
            '{8'hA5, 1'b1, 1'b0, NO_RESULT},
            // Text of letters only.
            '{"a", 1'b0, 1'b0, NO_RESULT},
            '{"0", 1'b1, 1'b1, EMPTY_RESULT}
        };

        repeat (10) @(negedge clk);
        rst_n = 1'b1;
        @(negedge clk);

        // Directed table.
        foreach (directed_rows[n]) begin
            typed_on  = directed_rows[n].typed;
            typed_res = directed_rows[n].result;
            drive_char(directed_rows[n].char_code, directed_rows[n].end_of_text);
        end
        typed_on = 1'b0;

        // Random texts, with one crowded text and a stall-free stretch.
        text_idx = 0;
        while (items_sent - $size(directed_rows) < RANDOM_ITEMS) begin
            no_idle = (text_idx >= 8 && text_idx < 16);
            if (text_idx == 3) send_crowded_text();
            else send_random_text();
            text_idx++;
        end
        no_idle     = 1'b0;
        in_ch.valid = 1'b0;

        // Drain the outstanding results.
        while (expected_numbers.size() != 0) @(negedge clk);
        repeat (DRAIN_CYCLES) @(negedge clk);

        if (fail_count == 0 && expected_numbers.size() == 0) begin
            $display("status: pass");
        end else begin
            $display("status: fail");
        end
        $finish;
    end

endmodule
